// ===== rtl/sle_pkg.sv =====
// Shared types, character codes and echo tables of the serial line editor.
package sle_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } sle_cmd_e;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_ARG     = 2'd1,
    KIND_SUMMARY = 2'd2,
    KIND_READ    = 2'd3
  } sle_kind_e;

  typedef enum logic [2:0] {
    CLS_EOL,
    CLS_IGNORE,
    CLS_DEL,
    CLS_ETX,
    CLS_ESC,
    CLS_PRINT
  } sle_class_e;

  typedef enum logic [2:0] {
    SEQ_PROMPT,
    SEQ_NL_PROMPT,
    SEQ_CTRLC,
    SEQ_ERASE,
    SEQ_BELL
  } sle_seq_e;

  typedef enum logic [2:0] {
    SRC_ROM,
    SRC_CHAR,
    SRC_ARG,
    SRC_SUM,
    SRC_READ
  } sle_src_e;

  localparam logic [7:0] KEY_NUL   = 8'h00;
  localparam logic [7:0] KEY_ETX   = 8'h03;
  localparam logic [7:0] KEY_BEL   = 8'h07;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_HASH  = 8'h23;
  localparam logic [7:0] KEY_SLASH = 8'h2F;
  localparam logic [7:0] KEY_C     = 8'h43;
  localparam logic [7:0] KEY_CARET = 8'h5E;
  localparam logic [7:0] KEY_TILDE = 8'h7E;
  localparam logic [7:0] KEY_DEL   = 8'h7F;

  localparam int ESC_SKIP = 2;

  // Echo text: "^C\n#/ " then "\b \b" then bell; sequences share the prompt tail.
  function automatic logic [7:0] echo_rom(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = KEY_CARET;
      4'd1:    ch = KEY_C;
      4'd2:    ch = KEY_LF;
      4'd3:    ch = KEY_HASH;
      4'd4:    ch = KEY_SLASH;
      4'd5:    ch = KEY_SPACE;
      4'd6:    ch = KEY_BS;
      4'd7:    ch = KEY_SPACE;
      4'd8:    ch = KEY_BS;
      4'd9:    ch = KEY_BEL;
      default: ch = KEY_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] seq_start(input sle_seq_e seq);
    logic [3:0] s;
    case (seq)
      SEQ_PROMPT:    s = 4'd3;
      SEQ_NL_PROMPT: s = 4'd2;
      SEQ_CTRLC:     s = 4'd0;
      SEQ_ERASE:     s = 4'd6;
      SEQ_BELL:      s = 4'd9;
      default:       s = 4'd9;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] seq_len(input sle_seq_e seq);
    logic [2:0] n;
    case (seq)
      SEQ_PROMPT:    n = 3'd3;
      SEQ_NL_PROMPT: n = 3'd4;
      SEQ_CTRLC:     n = 3'd6;
      SEQ_ERASE:     n = 3'd3;
      SEQ_BELL:      n = 3'd1;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  // Controller to datapath.
  typedef struct packed {
    logic      take_item;
    logic      store_byte;
    logic      fill_dec;
    logic      fill_clr;
    logic      skip_load;
    logic      skip_dec;
    logic      lock;
    logic      unlock;
    logic      echo_start;
    sle_seq_e  echo_seq;
    logic      echo_next;
    logic      scan_init;
    logic      scan_active;
    logic      scan_step;
    logic      tok_start;
    logic      arg_done;
    logic      too_set;
    logic      out_load;
    sle_src_e  out_src;
    logic      out_last;
  } sle_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    sle_cmd_e   cmd;
    sle_class_e cls;
    logic       is_lf;
    logic       accepting;
    logic       fill_zero;
    logic       fill_full;
    logic       skip_nz;
    logic       echo_last;
    logic       out_free;
    logic       at_end;
    logic       blank;
    logic       in_tok;
    logic       last_arg;
  } sle_stat_t;

  typedef struct packed {
    sle_kind_e  kind;
    logic [7:0] data_byte;
    logic [2:0] arg_index;
    logic [6:0] arg_start;
    logic [6:0] arg_length;
    logic [3:0] arg_count;
    logic       too_many;
    logic       last;
  } sle_res_t;

endpackage

// ===== rtl/sle_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface sle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic [6:0] read_index;

  modport source (output valid, output cmd, output rx_byte, output read_index, input ready);
  modport sink   (input valid, input cmd, input rx_byte, input read_index, output ready);
endinterface

interface sle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [2:0] arg_index;
  logic [6:0] arg_start;
  logic [6:0] arg_length;
  logic [3:0] arg_count;
  logic       too_many;
  logic       last;

  modport source (output valid, output kind, output data_byte, output arg_index,
                  output arg_start, output arg_length, output arg_count,
                  output too_many, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input arg_index,
                  input arg_start, input arg_length, input arg_count,
                  input too_many, input last, output ready);
endinterface

// ===== rtl/sle_datapath.sv =====
// Datapath: line store, edit counters, echo sequencer, tokenizer and result register.
module sle_datapath #(
  parameter int LINE_DEPTH = 128,
  parameter int MAX_ARGS   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sle_pkg::sle_ctl_t  ctl_i,
  output sle_pkg::sle_stat_t stat_o,
  input  logic [1:0]       in_cmd_i,
  input  logic [7:0]       in_rx_byte_i,
  input  logic [6:0]       in_read_index_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output sle_pkg::sle_res_t  res_o
);
  import sle_pkg::*;

  localparam int PW = $clog2(LINE_DEPTH);
  localparam int NW = $clog2(MAX_ARGS + 1);
  localparam int IW = ((PW > 7) ? PW : 7) + 1;

  // Captured input word
  sle_cmd_e    item_cmd_q;
  logic [7:0]  item_byte_q;
  logic [6:0]  item_idx_q;

  // Edit state
  logic [PW-1:0] fill_q;
  logic [1:0]    skip_q;
  logic          accepting_q;

  // Echo sequencer
  logic [3:0] echo_ptr_q;
  logic [2:0] echo_left_q;

  // Tokenizer
  logic [PW-1:0] len_q;
  logic [PW-1:0] pos_q;
  logic [PW-1:0] start_q;
  logic [NW-1:0] n_q;
  logic          tok_q;
  logic          too_q;

  // Line store
  logic [7:0]    mem_q [LINE_DEPTH];
  logic [7:0]    rdata_q;
  logic [PW-1:0] rd_addr;
  logic [IW-1:0] idx_ext;
  logic          read_oob;

  sle_res_t res_d, res_q;
  logic     out_valid_q;
  sle_class_e cls;

  assign idx_ext  = IW'(item_idx_q);
  assign read_oob = idx_ext >= IW'(LINE_DEPTH);

  always_comb begin
    if (ctl_i.scan_init) begin
      rd_addr = '0;
    end else if (ctl_i.scan_active) begin
      rd_addr = ctl_i.scan_step ? pos_q + PW'(1) : pos_q;
    end else begin
      rd_addr = idx_ext[PW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.store_byte) begin
      mem_q[fill_q] <= item_byte_q;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    case (item_byte_q)
      KEY_CR, KEY_LF:     cls = CLS_EOL;
      KEY_TAB, KEY_TILDE: cls = CLS_IGNORE;
      KEY_DEL:            cls = CLS_DEL;
      KEY_ETX:            cls = CLS_ETX;
      KEY_ESC:            cls = CLS_ESC;
      default:            cls = CLS_PRINT;
    endcase
  end

  always_comb begin
    stat_o.cmd       = item_cmd_q;
    stat_o.cls       = cls;
    stat_o.is_lf     = item_byte_q == KEY_LF;
    stat_o.accepting = accepting_q;
    stat_o.fill_zero = fill_q == '0;
    stat_o.fill_full = fill_q == PW'(LINE_DEPTH - 1);
    stat_o.skip_nz   = skip_q != '0;
    stat_o.echo_last = echo_left_q == 3'd1;
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.at_end    = (pos_q >= len_q) || (rdata_q == KEY_NUL);
    stat_o.blank     = (rdata_q == KEY_SPACE) || (rdata_q == KEY_TAB);
    stat_o.in_tok    = tok_q;
    stat_o.last_arg  = n_q == NW'(MAX_ARGS - 1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      skip_q      <= '0;
      accepting_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.store_byte) begin
        fill_q <= fill_q + PW'(1);
      end else if (ctl_i.fill_dec) begin
        fill_q <= fill_q - PW'(1);
      end else if (ctl_i.fill_clr) begin
        fill_q <= '0;
      end
      if (ctl_i.skip_load) begin
        skip_q <= 2'(ESC_SKIP);
      end else if (ctl_i.skip_dec) begin
        skip_q <= skip_q - 2'd1;
      end
      if (ctl_i.lock) begin
        accepting_q <= 1'b0;
      end else if (ctl_i.unlock) begin
        accepting_q <= 1'b1;
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.take_item) begin
      item_cmd_q  <= sle_cmd_e'(in_cmd_i);
      item_byte_q <= in_rx_byte_i;
      item_idx_q  <= in_read_index_i;
    end
    if (ctl_i.echo_start) begin
      echo_ptr_q  <= seq_start(ctl_i.echo_seq);
      echo_left_q <= seq_len(ctl_i.echo_seq);
    end else if (ctl_i.echo_next) begin
      echo_ptr_q  <= echo_ptr_q + 4'd1;
      echo_left_q <= echo_left_q - 3'd1;
    end
    if (ctl_i.scan_init) begin
      len_q <= fill_q;
      pos_q <= '0;
      n_q   <= '0;
      tok_q <= 1'b0;
      too_q <= 1'b0;
    end else begin
      if (ctl_i.scan_step) begin
        pos_q <= pos_q + PW'(1);
      end
      if (ctl_i.tok_start) begin
        start_q <= pos_q;
        tok_q   <= 1'b1;
      end else if (ctl_i.arg_done) begin
        tok_q <= 1'b0;
        n_q   <= n_q + NW'(1);
      end
      if (ctl_i.too_set) begin
        too_q <= 1'b1;
      end
    end
    if (ctl_i.out_load) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    res_d      = '0;
    res_d.last = ctl_i.out_last;
    case (ctl_i.out_src)
      SRC_ROM: begin
        res_d.kind      = KIND_ECHO;
        res_d.data_byte = echo_rom(echo_ptr_q);
      end
      SRC_CHAR: begin
        res_d.kind      = KIND_ECHO;
        res_d.data_byte = item_byte_q;
      end
      SRC_ARG: begin
        res_d.kind       = KIND_ARG;
        res_d.arg_index  = 3'(n_q);
        res_d.arg_start  = 7'(start_q);
        res_d.arg_length = 7'(pos_q - start_q);
      end
      SRC_SUM: begin
        res_d.kind      = KIND_SUMMARY;
        res_d.arg_count = 4'(n_q);
        res_d.too_many  = too_q;
      end
      SRC_READ: begin
        res_d.kind      = KIND_READ;
        res_d.data_byte = read_oob ? KEY_NUL : rdata_q;
      end
      default: res_d.kind = KIND_ECHO;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/sle_ctrl.sv =====
// Controller: sequences decode, echo, buffer read and the line-end argument scan.
module sle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sle_pkg::sle_stat_t stat_i,
  output sle_pkg::sle_ctl_t  ctl_o
);
  import sle_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ECHO,
    ST_CHAR,
    ST_READ,
    ST_SCAN,
    ST_SUM
  } state_e;

  state_e   state_q, state_d;
  sle_ctl_t ctl;

  assign in_ready_o = state_q == ST_IDLE;
  assign ctl_o      = ctl;

  always_comb begin
    state_d = state_q;
    ctl     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl.take_item = 1'b1;
          state_d       = ST_DECODE;
        end
      end

      ST_DECODE: begin
        case (stat_i.cmd)
          CMD_RELEASE: begin
            ctl.unlock     = 1'b1;
            ctl.echo_start = 1'b1;
            ctl.echo_seq   = SEQ_PROMPT;
            state_d        = ST_ECHO;
          end
          CMD_READ: state_d = ST_READ;
          CMD_BYTE: begin
            state_d = ST_IDLE;
            if (!stat_i.accepting || (stat_i.fill_full && !stat_i.is_lf)) begin
              state_d = ST_IDLE;
            end else if (stat_i.skip_nz) begin
              ctl.skip_dec = 1'b1;
            end else begin
              case (stat_i.cls)
                CLS_EOL: begin
                  if (stat_i.fill_zero) begin
                    ctl.echo_start = 1'b1;
                    ctl.echo_seq   = SEQ_NL_PROMPT;
                    state_d        = ST_ECHO;
                  end else begin
                    ctl.lock      = 1'b1;
                    ctl.scan_init = 1'b1;
                    ctl.fill_clr  = 1'b1;
                    state_d       = ST_SCAN;
                  end
                end
                CLS_DEL: begin
                  ctl.echo_start = 1'b1;
                  if (stat_i.fill_zero) begin
                    ctl.echo_seq = SEQ_BELL;
                  end else begin
                    ctl.echo_seq = SEQ_ERASE;
                    ctl.fill_dec = 1'b1;
                  end
                  state_d = ST_ECHO;
                end
                CLS_ETX: begin
                  ctl.fill_clr   = 1'b1;
                  ctl.echo_start = 1'b1;
                  ctl.echo_seq   = SEQ_CTRLC;
                  state_d        = ST_ECHO;
                end
                CLS_ESC:    ctl.skip_load = 1'b1;
                CLS_PRINT: begin
                  ctl.store_byte = 1'b1;
                  state_d        = ST_CHAR;
                end
                default: state_d = ST_IDLE;
              endcase
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_ECHO: begin
        if (stat_i.out_free) begin
          ctl.out_load  = 1'b1;
          ctl.out_src   = SRC_ROM;
          ctl.out_last  = stat_i.echo_last;
          ctl.echo_next = 1'b1;
          if (stat_i.echo_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_CHAR: begin
        if (stat_i.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_src  = SRC_CHAR;
          ctl.out_last = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_READ: begin
        if (stat_i.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_src  = SRC_READ;
          ctl.out_last = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_SCAN: begin
        ctl.scan_active = 1'b1;
        ctl.out_src     = SRC_ARG;
        if (stat_i.at_end) begin
          if (!stat_i.in_tok) begin
            state_d = ST_SUM;
          end else if (stat_i.out_free) begin
            ctl.out_load = 1'b1;
            ctl.arg_done = 1'b1;
            state_d      = ST_SUM;
          end
        end else if (stat_i.in_tok && stat_i.blank) begin
          if (stat_i.out_free) begin
            ctl.out_load = 1'b1;
            ctl.arg_done = 1'b1;
            if (stat_i.last_arg) begin
              ctl.too_set = 1'b1;
              state_d     = ST_SUM;
            end else begin
              ctl.scan_step = 1'b1;
            end
          end
        end else begin
          ctl.tok_start = !stat_i.in_tok && !stat_i.blank;
          ctl.scan_step = 1'b1;
        end
      end

      ST_SUM: begin
        if (stat_i.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_src  = SRC_SUM;
          ctl.out_last = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/serial_line_editor_tokenizer.sv =====
// Top level of the serial line editor with blank-separated argument tokenizer.
//
// One input word at a time: a received byte, a release of a finished line or a read of
// one line-buffer byte. A byte is decoded and then sends its result words, if any (echo
// characters, at most six); a buffer read sends a single result word. A line end
// starts the argument scan, which walks the line store at one byte per cycle, unless
// the sink holds ready low, through its single registered read port. The last result
// word waits in the output register while the next input word is already taken.
// After a non-empty line the editor stays locked (bytes are dropped silently) until a
// release word arrives; the stored line stays readable until new bytes overwrite it.
module serial_line_editor_tokenizer #(
  parameter int LINE_DEPTH = 128,
  parameter int MAX_ARGS   = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sle_in_if.sink    in_i,
  sle_out_if.source out_o
);
  import sle_pkg::*;

  sle_ctl_t  ctl;
  sle_stat_t stat;
  sle_res_t  res;
  logic      in_ready;
  logic      out_valid;

  // Sequencer: owns the handshake on the input side and every datapath command.
  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // Line store, counters, tokenizer and the output register.
  sle_datapath #(
    .LINE_DEPTH (LINE_DEPTH),
    .MAX_ARGS   (MAX_ARGS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .in_cmd_i        (in_i.cmd),
    .in_rx_byte_i    (in_i.rx_byte),
    .in_read_index_i (in_i.read_index),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_valid),
    .res_o           (res)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.kind       = res.kind;
  assign out_o.data_byte  = res.data_byte;
  assign out_o.arg_index  = res.arg_index;
  assign out_o.arg_start  = res.arg_start;
  assign out_o.arg_length = res.arg_length;
  assign out_o.arg_count  = res.arg_count;
  assign out_o.too_many   = res.too_many;
  assign out_o.last       = res.last;

  // One word in flight: taking a word closes the input until its work is done.
  a_single_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a word is still being worked on");

  // Overflow flag only comes with a full argument count.
  a_too_many_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.too_many) |-> (out_o.kind == KIND_SUMMARY &&
                                         out_o.arg_count == 4'(MAX_ARGS)))
    else $error("too_many set without a full argument count");

  // An argument always holds at least one non-blank byte.
  a_arg_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_ARG) |-> (out_o.arg_length != 7'd0 &&
                                                 !out_o.last))
    else $error("empty argument record or argument marked last");

endmodule
